### design/sacb_pkg.sv
`default_nettype none

package sacb_pkg;

    // Field widths of the stream payloads.
    localparam int LCP_W   = 12;
    localparam int INDEX_W = 12;
    localparam int CHILD_W = 12;
    localparam int OP_W    = 2;

    // Operation codes carried in the input tuser field.
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIRST,
        ST_UD_CHECK,
        ST_UD_SETTLE,
        ST_NL_CHECK,
        ST_NL_SETTLE,
        ST_RD_ISSUE,
        ST_RD_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic clear_start;
        logic clear_step;
        logic first_append;
        logic ud_pop;
        logic ud_settle;
        logic ud_push;
        logic nl_pop;
        logic nl_settle;
        logic nl_finish;
        logic rd_issue;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic first_pos;
        logic table_full;
        logic ud_pop_ok;
        logic nl_pop_ok;
        logic clear_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### design/sacb_ram.sv
`default_nettype none

module sacb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/sacb_ctrl.sv
`default_nettype none

module sacb_ctrl
    import sacb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [OP_W-1:0]  in_op,
    output logic                  in_ready,
    input  wire sts_t             sts,
    output cmd_t                  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // State register; reset starts the clearing pass over the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_APPEND)
                    begin
                        if (sts.table_full)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (sts.first_pos)
                        begin
                            state_next = ST_FIRST;
                        end
                        else
                        begin
                            state_next = ST_UD_CHECK;
                        end
                    end
                    else if (in_op == OP_READ)
                    begin
                        state_next = ST_RD_ISSUE;
                    end
                    else if (in_op == OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_FIRST:     state_next = ST_IDLE;
            ST_UD_CHECK:  state_next = sts.ud_pop_ok ? ST_UD_SETTLE : ST_NL_CHECK;
            ST_UD_SETTLE: state_next = ST_UD_CHECK;
            ST_NL_CHECK:  state_next = sts.nl_pop_ok ? ST_NL_SETTLE : ST_IDLE;
            ST_NL_SETTLE: state_next = ST_NL_CHECK;
            ST_RD_ISSUE:  state_next = ST_RD_OUT;
            ST_RD_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load_item   = accept;
                cmd.clear_start = accept && (in_op == OP_CLEAR);
            end
            ST_FIRST:
            begin
                cmd.first_append = 1'b1;
            end
            ST_UD_CHECK:
            begin
                cmd.ud_pop  = sts.ud_pop_ok;
                cmd.ud_push = !sts.ud_pop_ok;
            end
            ST_UD_SETTLE:
            begin
                cmd.ud_settle = 1'b1;
            end
            ST_NL_CHECK:
            begin
                cmd.nl_pop    = sts.nl_pop_ok;
                cmd.nl_finish = !sts.nl_pop_ok;
            end
            ST_NL_SETTLE:
            begin
                cmd.nl_settle = 1'b1;
            end
            ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_RD_OUT:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/sacb_datapath.sv
`default_nettype none

module sacb_datapath
    import sacb_pkg::*;
#(
    parameter int MAX_SUFFIXES = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic [LCP_W-1:0]   lcp_value,
    input  wire logic [INDEX_W-1:0] read_index,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic [CHILD_W-1:0]      child_value,
    output logic [INDEX_W-1:0]      entry_index
);

    localparam int AW = $clog2(MAX_SUFFIXES);
    localparam int CW = $clog2(MAX_SUFFIXES + 1);
    localparam int SW = AW + LCP_W;

    // Control registers.
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] ud_depth_reg, ud_depth_next;
    logic [CW-1:0] nl_depth_reg, nl_depth_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          lp_valid_reg, lp_valid_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers.
    logic [LCP_W-1:0]   lcp_reg, lcp_next;
    logic [INDEX_W-1:0] rd_index_reg, rd_index_next;
    logic               in_range_reg, in_range_next;
    logic [AW-1:0]      ud_top_idx_reg, ud_top_idx_next;
    logic [LCP_W-1:0]   ud_top_lcp_reg, ud_top_lcp_next;
    logic [AW-1:0]      nl_top_idx_reg, nl_top_idx_next;
    logic [LCP_W-1:0]   nl_top_lcp_reg, nl_top_lcp_next;
    logic [AW-1:0]      pop_idx_reg, pop_idx_next;
    logic [LCP_W-1:0]   pop_lcp_reg, pop_lcp_next;
    logic [CHILD_W-1:0] out_child_reg, out_child_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;

    // Memory ports.
    logic               ud_stk_we, nl_stk_we, ud_tab_we, nl_tab_we;
    logic [AW-1:0]      ud_stk_wa, nl_stk_wa, ud_tab_wa, nl_tab_wa;
    logic [SW-1:0]      ud_stk_wd, nl_stk_wd;
    logic [SW-1:0]      ud_stk_rd, nl_stk_rd;
    logic [CHILD_W-1:0] ud_tab_wd, ud_tab_rd;
    logic [CHILD_W:0]   nl_tab_wd, nl_tab_rd;

    logic [AW-1:0]    cur_pos;
    logic [AW-1:0]    prev_pos;
    logic [CW-1:0]    ud_below, nl_below, nl_top_slot;
    logic [AW-1:0]    ud_rd_idx;
    logic [LCP_W-1:0] ud_rd_lcp;
    logic [AW-1:0]    nl_rd_idx;
    logic [LCP_W-1:0] nl_rd_lcp;
    logic             ud_link_ok;
    logic             nl_eq;
    logic [SW-1:0]    new_entry;

    assign cur_pos     = pos_reg[AW-1:0];
    assign prev_pos    = cur_pos - AW'(1);
    assign ud_below    = ud_depth_reg - CW'(2);
    assign nl_below    = nl_depth_reg - CW'(2);
    assign nl_top_slot = nl_depth_reg - CW'(1);
    assign ud_rd_idx   = ud_stk_rd[SW-1:LCP_W];
    assign ud_rd_lcp   = ud_stk_rd[LCP_W-1:0];
    assign nl_rd_idx   = nl_stk_rd[SW-1:LCP_W];
    assign nl_rd_lcp   = nl_stk_rd[LCP_W-1:0];
    assign ud_link_ok  = (lcp_reg <= ud_rd_lcp) && (ud_rd_lcp != pop_lcp_reg);
    assign nl_eq       = (lcp_reg == nl_top_lcp_reg);
    assign new_entry   = {cur_pos, lcp_reg};

    // Status to the controller.
    always_comb
    begin
        sts.first_pos  = (pos_reg == '0);
        sts.table_full = (pos_reg == CW'(MAX_SUFFIXES));
        sts.ud_pop_ok  = (ud_depth_reg > CW'(1)) && (lcp_reg < ud_top_lcp_reg);
        sts.nl_pop_ok  = (nl_depth_reg > CW'(1)) && (lcp_reg < nl_top_lcp_reg);
        sts.clear_last = (clr_addr_reg == AW'(MAX_SUFFIXES - 1));
        sts.out_free   = !out_valid_reg || result_ready;
    end

    // Stack memory ports.
    always_comb
    begin
        ud_stk_we = cmd.first_append || cmd.ud_push;
        ud_stk_wa = cmd.first_append ? '0 : ud_depth_reg[AW-1:0];
        ud_stk_wd = cmd.first_append ? '0 : new_entry;

        nl_stk_we = cmd.first_append || cmd.nl_finish;
        if (cmd.first_append)
        begin
            nl_stk_wa = '0;
        end
        else if (nl_eq)
        begin
            nl_stk_wa = nl_top_slot[AW-1:0];
        end
        else
        begin
            nl_stk_wa = nl_depth_reg[AW-1:0];
        end
        nl_stk_wd = cmd.first_append ? '0 : new_entry;
    end

    // Table memory ports: up/down links and marked next-l-index links are
    // kept apart, and a mark on a position makes its next-l-index link win.
    always_comb
    begin
        ud_tab_we = 1'b0;
        ud_tab_wa = clr_addr_reg;
        ud_tab_wd = '0;
        if (cmd.clear_step)
        begin
            ud_tab_we = 1'b1;
        end
        else if (cmd.ud_settle && ud_link_ok)
        begin
            ud_tab_we = 1'b1;
            ud_tab_wa = ud_rd_idx;
            ud_tab_wd = CHILD_W'(pop_idx_reg);
        end
        else if (cmd.ud_push && lp_valid_reg)
        begin
            ud_tab_we = 1'b1;
            ud_tab_wa = prev_pos;
            ud_tab_wd = CHILD_W'(pop_idx_reg);
        end

        nl_tab_we = 1'b0;
        nl_tab_wa = clr_addr_reg;
        nl_tab_wd = '0;
        if (cmd.clear_step)
        begin
            nl_tab_we = 1'b1;
        end
        else if (cmd.nl_finish && nl_eq)
        begin
            nl_tab_we = 1'b1;
            nl_tab_wa = nl_top_idx_reg;
            nl_tab_wd = {1'b1, CHILD_W'(cur_pos)};
        end
    end

    sacb_ram #(.WIDTH(SW), .DEPTH(MAX_SUFFIXES)) u_ud_stack (
        .clk     (clk),
        .wr_en   (ud_stk_we),
        .wr_addr (ud_stk_wa),
        .wr_data (ud_stk_wd),
        .rd_en   (cmd.ud_pop),
        .rd_addr (ud_below[AW-1:0]),
        .rd_data (ud_stk_rd)
    );

    sacb_ram #(.WIDTH(SW), .DEPTH(MAX_SUFFIXES)) u_nl_stack (
        .clk     (clk),
        .wr_en   (nl_stk_we),
        .wr_addr (nl_stk_wa),
        .wr_data (nl_stk_wd),
        .rd_en   (cmd.nl_pop),
        .rd_addr (nl_below[AW-1:0]),
        .rd_data (nl_stk_rd)
    );

    sacb_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_SUFFIXES)) u_ud_table (
        .clk     (clk),
        .wr_en   (ud_tab_we),
        .wr_addr (ud_tab_wa),
        .wr_data (ud_tab_wd),
        .rd_en   (cmd.rd_issue),
        .rd_addr (AW'(rd_index_reg)),
        .rd_data (ud_tab_rd)
    );

    sacb_ram #(.WIDTH(CHILD_W + 1), .DEPTH(MAX_SUFFIXES)) u_nl_table (
        .clk     (clk),
        .wr_en   (nl_tab_we),
        .wr_addr (nl_tab_wa),
        .wr_data (nl_tab_wd),
        .rd_en   (cmd.rd_issue),
        .rd_addr (AW'(rd_index_reg)),
        .rd_data (nl_tab_rd)
    );

    // Next values of the control registers.
    always_comb
    begin
        pos_next       = pos_reg;
        ud_depth_next  = ud_depth_reg;
        nl_depth_next  = nl_depth_reg;
        clr_addr_next  = clr_addr_reg;
        lp_valid_next  = lp_valid_reg;
        out_valid_next = out_valid_reg;

        if (cmd.clear_start)
        begin
            pos_next      = '0;
            ud_depth_next = '0;
            nl_depth_next = '0;
            clr_addr_next = '0;
        end
        if (cmd.clear_step)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end
        if (cmd.load_item)
        begin
            lp_valid_next = 1'b0;
        end
        if (cmd.first_append)
        begin
            ud_depth_next = CW'(1);
            nl_depth_next = CW'(1);
            pos_next      = CW'(1);
        end
        if (cmd.ud_pop)
        begin
            ud_depth_next = ud_depth_reg - CW'(1);
            lp_valid_next = 1'b1;
        end
        if (cmd.ud_push)
        begin
            ud_depth_next = ud_depth_reg + CW'(1);
            lp_valid_next = 1'b0;
        end
        if (cmd.nl_pop)
        begin
            nl_depth_next = nl_depth_reg - CW'(1);
        end
        if (cmd.nl_finish)
        begin
            // An equal top is replaced in place; otherwise the stack grows.
            if (!nl_eq)
            begin
                nl_depth_next = nl_depth_reg + CW'(1);
            end
            pos_next = pos_reg + CW'(1);
        end

        // Output register: loaded by a read, emptied by the receiver.
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Next values of the payload registers.
    always_comb
    begin
        lcp_next        = lcp_reg;
        rd_index_next   = rd_index_reg;
        in_range_next   = in_range_reg;
        ud_top_idx_next = ud_top_idx_reg;
        ud_top_lcp_next = ud_top_lcp_reg;
        nl_top_idx_next = nl_top_idx_reg;
        nl_top_lcp_next = nl_top_lcp_reg;
        pop_idx_next    = pop_idx_reg;
        pop_lcp_next    = pop_lcp_reg;
        out_child_next  = out_child_reg;
        out_index_next  = out_index_reg;

        if (cmd.load_item)
        begin
            lcp_next      = lcp_value;
            rd_index_next = read_index;
            in_range_next = (32'(read_index) < 32'(MAX_SUFFIXES));
        end
        if (cmd.first_append)
        begin
            ud_top_idx_next = '0;
            ud_top_lcp_next = '0;
            nl_top_idx_next = '0;
            nl_top_lcp_next = '0;
        end
        if (cmd.ud_pop)
        begin
            pop_idx_next = ud_top_idx_reg;
            pop_lcp_next = ud_top_lcp_reg;
        end
        if (cmd.ud_settle)
        begin
            ud_top_idx_next = ud_rd_idx;
            ud_top_lcp_next = ud_rd_lcp;
        end
        if (cmd.ud_push)
        begin
            ud_top_idx_next = cur_pos;
            ud_top_lcp_next = lcp_reg;
        end
        if (cmd.nl_settle)
        begin
            nl_top_idx_next = nl_rd_idx;
            nl_top_lcp_next = nl_rd_lcp;
        end
        if (cmd.nl_finish)
        begin
            nl_top_idx_next = cur_pos;
            nl_top_lcp_next = lcp_reg;
        end
        if (cmd.out_load)
        begin
            out_index_next = rd_index_reg;
            if (!in_range_reg)
            begin
                out_child_next = '0;
            end
            else if (nl_tab_rd[CHILD_W])
            begin
                out_child_next = nl_tab_rd[CHILD_W-1:0];
            end
            else
            begin
                out_child_next = ud_tab_rd;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ud_depth_reg  <= '0;
            nl_depth_reg  <= '0;
            clr_addr_reg  <= '0;
            lp_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            ud_depth_reg  <= ud_depth_next;
            nl_depth_reg  <= nl_depth_next;
            clr_addr_reg  <= clr_addr_next;
            lp_valid_reg  <= lp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lcp_reg        <= lcp_next;
        rd_index_reg   <= rd_index_next;
        in_range_reg   <= in_range_next;
        ud_top_idx_reg <= ud_top_idx_next;
        ud_top_lcp_reg <= ud_top_lcp_next;
        nl_top_idx_reg <= nl_top_idx_next;
        nl_top_lcp_reg <= nl_top_lcp_next;
        pop_idx_reg    <= pop_idx_next;
        pop_lcp_reg    <= pop_lcp_next;
        out_child_reg  <= out_child_next;
        out_index_reg  <= out_index_next;
    end

    assign result_valid = out_valid_reg;
    assign child_value  = out_child_reg;
    assign entry_index  = out_index_reg;

endmodule

`default_nettype wire

### design/suffix_array_child_table_builder.sv
// Child table builder for an enhanced suffix array.
// Input stream (s_axis): tuser carries the operation (append an LCP value, read a child
// entry, clear and restart); tdata carries the LCP value and the read position.
// Output stream (m_axis): one transaction per read, with the stored child entry and the
// echoed position. Appends and clears produce no output transaction.
// An append after the first runs the up/down stack pass and then the next-l-index pass
// before the next transaction can be accepted; each entry popped from either stack adds
// a check state and a settle state. The stack tops are held in registers and each pop
// waits on one registered read of the stack memory. A read passes an issue state and an
// output state and shows its result in the output register.
// After reset, and after each clear transaction, the block sweeps all MAX_SUFFIXES
// child table entries with s_axis_tready low before it accepts the next transaction.
// A result waits in the output register while the receiver stalls; the block keeps
// accepting appends meanwhile, and a following read waits until that register empties.
`default_nettype none

module suffix_array_child_table_builder
    import sacb_pkg::*;
#(
    parameter int MAX_SUFFIXES = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // [11:0] lcp_value, [23:12] read_index
    input  wire logic [LCP_W+INDEX_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  wire logic [OP_W-1:0]          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // [11:0] child_value, [23:12] entry_index
    output logic [CHILD_W+INDEX_W-1:0]    m_axis_tdata
);

    cmd_t               cmd;
    sts_t               sts;
    logic [CHILD_W-1:0] child_value;
    logic [INDEX_W-1:0] entry_index;

    // Sequencer for clear sweeps, stack passes and reads.
    sacb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stacks, child table memories and the output register.
    sacb_datapath #(.MAX_SUFFIXES(MAX_SUFFIXES)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .lcp_value    (s_axis_tdata[LCP_W-1:0]),
        .read_index   (s_axis_tdata[LCP_W+INDEX_W-1:LCP_W]),
        .result_valid (m_axis_tvalid),
        .result_ready (m_axis_tready),
        .child_value  (child_value),
        .entry_index  (entry_index)
    );

    assign m_axis_tdata = {entry_index, child_value};

endmodule

`default_nettype wire

### design/sacb_checker.sv
`default_nettype none

module sacb_checker
    import sacb_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic [LCP_W+INDEX_W-1:0]   s_axis_tdata,
    input wire logic [OP_W-1:0]            s_axis_tuser,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [CHILD_W+INDEX_W-1:0] m_axis_tdata
);

    logic in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // A stalled result holds its payload.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed or dropped while stalled");

    // Reads and clears always keep the block busy for the following cycle.
    property p_busy_after;
        @(posedge clk) disable iff (!rst_n)
        in_accept && (s_axis_tuser == OP_READ || s_axis_tuser == OP_CLEAR)
            |=> !s_axis_tready;
    endproperty
    a_busy_after: assert property (p_busy_after)
        else $error("input accepted while a read or clear is in progress");

    // A fresh result appears only after its read was accepted.
    property p_result_source;
        @(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_accept && s_axis_tuser == OP_READ, 3);
    endproperty
    a_result_source: assert property (p_result_source)
        else $error("result without a matching read");

    // The echoed position matches the position of that read.
    property p_echo;
        @(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid)
            |-> m_axis_tdata[CHILD_W+INDEX_W-1:CHILD_W]
                == $past(s_axis_tdata[LCP_W+INDEX_W-1:LCP_W], 3);
    endproperty
    a_echo: assert property (p_echo)
        else $error("echoed position differs from the read position");

endmodule

bind suffix_array_child_table_builder sacb_checker u_checker (.*);

`default_nettype wire

### sim/suffix_array_child_table_builder_tb.sv
`timescale 1ns / 1ps

module suffix_array_child_table_builder_tb;
    import sacb_pkg::*;

    localparam int TABLE_SIZE = 4096;
    localparam int PERIOD = 20;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 400;

    // Operation code that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Expected contents of one read transaction on the output stream.
    typedef struct {
        logic [CHILD_W-1:0] child_value;
        logic [INDEX_W-1:0] entry_index;
    } read_result_t;

    // Tracks the child table as the block should build it and holds the
    // read results that are still due.
    class child_table_tracker;
        int ud_idx[TABLE_SIZE];
        int ud_lcp[TABLE_SIZE];
        int ud_depth;
        int nl_idx[TABLE_SIZE];
        int nl_lcp[TABLE_SIZE];
        int nl_depth;
        int filled;
        logic [CHILD_W-1:0] child[TABLE_SIZE];
        bit marked[TABLE_SIZE];
        read_result_t pending_reads[$];
        int errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        // Empty both stacks, restart the scan and zero the table and marks.
        function void wipe();
            filled = 0;
            ud_depth = 0;
            nl_depth = 0;
            for (int k = 0; k < TABLE_SIZE; k++)
            begin
                child[k] = '0;
                marked[k] = 1'b0;
            end
        endfunction

        // An up/down link never overwrites an entry that holds a next-l-index.
        function void link_updown(int pos, int val);
            if (pos < TABLE_SIZE && !marked[pos])
                child[pos] = val[CHILD_W-1:0];
        endfunction

        // Advance the scan by one LCP value.
        function void scan_lcp(logic [LCP_W-1:0] lcp_in);
            int pos;
            int lv;
            int popped;
            int top_idx;
            int top_lcp;
            int below_lcp;
            int hit;
            pos = filled;
            lv = int'(lcp_in);
            if (pos >= TABLE_SIZE)
                return;
            // The first position seeds both stacks with the bottom pair.
            if (pos == 0)
            begin
                ud_idx[0] = 0;
                ud_lcp[0] = 0;
                ud_depth = 1;
                nl_idx[0] = 0;
                nl_lcp[0] = 0;
                nl_depth = 1;
                filled = 1;
                return;
            end

            // Up/down links.
            popped = -1;
            while (ud_depth > 1 && lv < ud_lcp[ud_depth-1])
            begin
                ud_depth--;
                top_idx = ud_idx[ud_depth];
                top_lcp = ud_lcp[ud_depth];
                popped = top_idx;
                below_lcp = ud_lcp[ud_depth-1];
                if (lv <= below_lcp && below_lcp != top_lcp)
                    link_updown(ud_idx[ud_depth-1], top_idx);
            end
            if (popped >= 0)
                link_updown(pos - 1, popped);
            if (ud_depth < TABLE_SIZE)
            begin
                ud_idx[ud_depth] = pos;
                ud_lcp[ud_depth] = lv;
                ud_depth++;
            end

            // Next-l-index links.
            while (nl_depth > 1 && lv < nl_lcp[nl_depth-1])
                nl_depth--;
            if (nl_depth > 0 && lv == nl_lcp[nl_depth-1])
            begin
                nl_depth--;
                hit = nl_idx[nl_depth];
                child[hit] = pos[CHILD_W-1:0];
                marked[hit] = 1'b1;
            end
            if (nl_depth < TABLE_SIZE)
            begin
                nl_idx[nl_depth] = pos;
                nl_lcp[nl_depth] = lv;
                nl_depth++;
            end
            filled = pos + 1;
        endfunction

        // Note one transaction accepted on the input stream.
        function void accept_item(logic [OP_W-1:0] op, logic [LCP_W-1:0] lcp,
                                  logic [INDEX_W-1:0] ridx);
            read_result_t due;
            if (op == OP_APPEND)
                scan_lcp(lcp);
            else if (op == OP_READ)
            begin
                due.child_value = child[ridx];
                due.entry_index = ridx;
                pending_reads.push_back(due);
            end
            else if (op == OP_CLEAR)
                wipe();
        endfunction

        task report(string what, int expected_val, int got_val);
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, expected_val,
                     got_val, $realtime);
            errors++;
        endtask

        // Compare one output transaction with the oldest read still due.
        task check_read(logic [CHILD_W-1:0] child_got, logic [INDEX_W-1:0] index_got);
            read_result_t due;
            if (pending_reads.size() == 0)
            begin
                report("unexpected read result, entry_index", -1, int'(index_got));
                return;
            end
            due = pending_reads.pop_front();
            if (child_got !== due.child_value)
                report("child_value", int'(due.child_value), int'(child_got));
            if (index_got !== due.entry_index)
                report("entry_index", int'(due.entry_index), int'(index_got));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [LCP_W+INDEX_W-1:0] s_axis_tdata;
    logic [OP_W-1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [CHILD_W+INDEX_W-1:0] m_axis_tdata;

    child_table_tracker tracker = new();
    bit no_idle = 1'b0;
    int random_items = 0;
    int cycles = 0;

    suffix_array_child_table_builder #(
        .MAX_SUFFIXES(TABLE_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #(PERIOD/2) clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Idle cycles before the next transaction on either side.
    function automatic int pick_wait();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Present one transaction on the input stream and wait until it is taken.
    // Entered and left at a falling edge.
    task send(logic [OP_W-1:0] op, logic [LCP_W-1:0] lcp, logic [INDEX_W-1:0] ridx);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser = op;
        s_axis_tdata = {ridx, lcp};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.accept_item(op, lcp, ridx);
        @(negedge clk);
    endtask

    // The field that an operation does not use carries random bits.
    task append(logic [LCP_W-1:0] lcp);
        send(OP_APPEND, lcp, INDEX_W'($urandom));
    endtask

    task read_entry(logic [INDEX_W-1:0] ridx);
        send(OP_READ, LCP_W'($urandom), ridx);
    endtask

    // Hold the input stream until every read result has come back.
    task wait_drained();
        s_axis_tvalid = 1'b0;
        while (tracker.pending_reads.size() != 0)
            @(negedge clk);
    endtask

    // Output side: stall at random, then take one transaction and check it.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_wait();
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            tracker.check_read(m_axis_tdata[CHILD_W-1:0],
                               m_axis_tdata[CHILD_W+INDEX_W-1:CHILD_W]);
            @(negedge clk);
        end
    end

    // Short directed sequence over the corner cases.
    task run_directed();
        // Reads right after reset see an all-zero table.
        read_entry(INDEX_W'(0));
        read_entry(INDEX_W'(TABLE_SIZE - 1));
        // The unused operation code with every data bit set does nothing.
        send(OP_UNUSED, '1, '1);
        // The first value is taken as zero whatever it carries.
        append(12'hFFF);
        append(LCP_W'(2));
        append(LCP_W'(1));
        // A read in the middle of a scan sees the table as it stands.
        read_entry(INDEX_W'(0));
        append(LCP_W'(3));
        append(LCP_W'(3));
        append(LCP_W'(1));
        append(LCP_W'(0));
        append(LCP_W'(2));
        append(12'hFFF);
        append(LCP_W'(0));
        read_entry(INDEX_W'(1));
        read_entry(INDEX_W'(3));
        read_entry(INDEX_W'(4));
        read_entry(INDEX_W'(8));
        // A clear zeroes the table.
        send(OP_CLEAR, LCP_W'($urandom), INDEX_W'($urandom));
        read_entry(INDEX_W'(3));
    endtask

    // Random scans: mostly plausible LCP runs with reads mixed in.
    task run_random();
        int scan_len;
        int lcp_top;
        int pick;
        int first_scan;
        first_scan = 1;
        while (random_items < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            if (first_scan || $urandom_range(0, 4) != 0)
            begin
                send(OP_CLEAR, LCP_W'($urandom), INDEX_W'($urandom));
                random_items++;
            end
            lcp_top = $urandom_range(1, 12);
            scan_len = $urandom_range(2, 60);
            for (int j = 0; j < scan_len; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send(OP_UNUSED, LCP_W'($urandom), INDEX_W'($urandom));
                else if (pick < 25)
                begin
                    if ($urandom_range(0, 4) == 0)
                        read_entry(INDEX_W'($urandom));
                    else
                        read_entry(INDEX_W'($urandom_range(0, tracker.filled + 1)));
                    random_items++;
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        append(LCP_W'($urandom));
                    else
                        append(LCP_W'($urandom_range(0, lcp_top)));
                    random_items++;
                end
            end
            // Read back the whole scan now and then.
            if ($urandom_range(0, 1) == 0)
            begin
                for (int k = 0; k <= tracker.filled; k++)
                begin
                    read_entry(INDEX_W'(k));
                    random_items++;
                end
            end
            if (first_scan || $urandom_range(0, 3) == 0)
                wait_drained();
            first_scan = 0;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_APPEND;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random();

        s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (20) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending_reads.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### suffix_array_child_table_builder.f
design/sacb_pkg.sv
design/sacb_ram.sv
design/sacb_ctrl.sv
design/sacb_datapath.sv
design/suffix_array_child_table_builder.sv
design/sacb_checker.sv
sim/suffix_array_child_table_builder_tb.sv
